// ===== hdl/rbu_pkg.sv =====
// rbu_pkg: shared types and codes for the RGBA blend unit.
// Holds factor, equation and register index codes plus the lane control structs.
// No dependencies; imported by every module of the block.
package rbu_pkg;

   localparam int NUM_CH         = 4;
   localparam int ALPHA_CH       = 3;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int FACTOR_BITS    = 4;
   localparam int EQUATION_BITS  = 3;
   localparam int WRCTL_BITS     = 6;
   localparam int WRCTL_DEPTH_WE = 4;
   localparam int WRCTL_BLEND_EN = 5;

   typedef enum logic [FACTOR_BITS-1:0] {
      FACTOR_ZERO             = 4'd0,
      FACTOR_ONE              = 4'd1,
      FACTOR_SRC_COLOR        = 4'd2,
      FACTOR_ONE_MINUS_SRC    = 4'd3,
      FACTOR_DST_COLOR        = 4'd4,
      FACTOR_ONE_MINUS_DST    = 4'd5,
      FACTOR_SRC_ALPHA        = 4'd6,
      FACTOR_ONE_MINUS_SRCA   = 4'd7,
      FACTOR_DST_ALPHA        = 4'd8,
      FACTOR_ONE_MINUS_DSTA   = 4'd9,
      FACTOR_CONST_COLOR      = 4'd10,
      FACTOR_ONE_MINUS_CONST  = 4'd11,
      FACTOR_CONST_ALPHA      = 4'd12,
      FACTOR_ONE_MINUS_CONSTA = 4'd13,
      FACTOR_SATURATE         = 4'd14
   } rbu_factor_type;

   typedef enum logic [EQUATION_BITS-1:0] {
      EQ_ADD     = 3'd0,
      EQ_SUB     = 3'd1,
      EQ_REV_SUB = 3'd2,
      EQ_MIN     = 3'd3,
      EQ_MAX     = 3'd4
   } rbu_equation_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SRC_RGB_FACTOR   = 3'd0,
      CSR_DST_RGB_FACTOR   = 3'd1,
      CSR_SRC_ALPHA_FACTOR = 3'd2,
      CSR_DST_ALPHA_FACTOR = 3'd3,
      CSR_RGB_EQUATION     = 3'd4,
      CSR_ALPHA_EQUATION   = 3'd5,
      CSR_CONSTANT_COLOUR  = 3'd6,
      CSR_WRITE_CONTROL    = 3'd7
   } rbu_csr_type;

   // Per-lane blend setup, taken from the configuration registers.
   typedef struct packed {
      rbu_factor_type   src_factor;
      rbu_factor_type   dst_factor;
      rbu_equation_type equation;
      logic             blend_en;
   } rbu_lane_cfg_type;

   // Stage load strobes shared by all lanes.
   typedef struct packed {
      logic load1;
      logic load2;
   } rbu_pipe_ctrl_type;

   // Write flags carried beside the colour; chan_we sits in the low bits.
   typedef struct packed {
      logic                    depth_we;
      logic [NUM_CH-1:0]       chan_we;
   } rbu_wr_flags_type;

endpackage

// ===== hdl/rbu_lane.sv =====
// rbu_lane: one colour channel of the blend datapath (factor, scale, combine).
// Two register stages; the combine result leaves combinationally for the merge stage.
// Depends on rbu_pkg.
module rbu_lane #(
   parameter int CHANNEL_BITS = 8,
   parameter bit IS_ALPHA     = 1'b0
) (
   input  logic                         clock,
   input  rbu_pkg::rbu_pipe_ctrl_type   pipe_ctrl,
   input  rbu_pkg::rbu_lane_cfg_type    lane_cfg,
   input  logic [CHANNEL_BITS-1:0]      src_chan,
   input  logic [CHANNEL_BITS-1:0]      dst_chan,
   input  logic [CHANNEL_BITS-1:0]      src_alpha,
   input  logic [CHANNEL_BITS-1:0]      dst_alpha,
   input  logic [CHANNEL_BITS-1:0]      const_chan,
   input  logic [CHANNEL_BITS-1:0]      const_alpha,
   output logic [CHANNEL_BITS-1:0]      lane_result
);
   import rbu_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam int PW = 2 * CB;
   localparam int RW = 2 * CB + 3;
   localparam logic [CB-1:0] MAXV = {CB{1'b1}};
   localparam logic [PW:0]   HALF = (PW + 1)'(1) << (CB - 1);

   function automatic logic [CB-1:0] pick_factor(
      input rbu_factor_type code,
      input logic [CB-1:0]  s,
      input logic [CB-1:0]  d,
      input logic [CB-1:0]  sa,
      input logic [CB-1:0]  da,
      input logic [CB-1:0]  k,
      input logic [CB-1:0]  ka
   );
      logic [CB-1:0] f;
      logic [CB-1:0] inv_da;
      inv_da = MAXV - da;
      case (code)
         FACTOR_ZERO:             f = '0;
         FACTOR_ONE:              f = MAXV;
         FACTOR_SRC_COLOR:        f = s;
         FACTOR_ONE_MINUS_SRC:    f = MAXV - s;
         FACTOR_DST_COLOR:        f = d;
         FACTOR_ONE_MINUS_DST:    f = MAXV - d;
         FACTOR_SRC_ALPHA:        f = sa;
         FACTOR_ONE_MINUS_SRCA:   f = MAXV - sa;
         FACTOR_DST_ALPHA:        f = da;
         FACTOR_ONE_MINUS_DSTA:   f = inv_da;
         FACTOR_CONST_COLOR:      f = k;
         FACTOR_ONE_MINUS_CONST:  f = MAXV - k;
         FACTOR_CONST_ALPHA:      f = ka;
         FACTOR_ONE_MINUS_CONSTA: f = MAXV - ka;
         FACTOR_SATURATE:         f = IS_ALPHA ? MAXV : ((sa < inv_da) ? sa : inv_da);
         default:                 f = MAXV;
      endcase
      return f;
   endfunction

   // Round x / MAXV: estimate with the shift-add trick, then fix it up by one step.
   function automatic logic [CB-1:0] round_div(input logic [PW-1:0] x);
      logic [PW:0]              t;
      logic [PW:0]              u;
      logic [CB:0]              q;
      logic signed [RW-1:0]     r;
      t = (PW + 1)'(x) + HALF;
      u = t + (t >> CB);
      q = u[PW:CB];
      r = $signed(RW'(x)) + $signed(RW'(MAXV >> 1)) - $signed(RW'(q) << CB)
          + $signed(RW'(q));
      if (r < 0) begin
         q = q - 1'b1;
      end else if (r >= $signed(RW'(MAXV))) begin
         q = q + 1'b1;
      end
      return q[CB-1:0];
   endfunction

   logic [CB-1:0] src_factor;
   logic [CB-1:0] dst_factor;
   logic [PW-1:0] prod_src_in, prod_src_ff;
   logic [PW-1:0] prod_dst_in, prod_dst_ff;
   logic [CB-1:0] src1_ff, dst1_ff;
   logic [CB-1:0] term_src_in, term_src_ff;
   logic [CB-1:0] term_dst_in, term_dst_ff;
   logic [CB-1:0] src2_ff, dst2_ff;
   logic [CB:0]   sum;
   logic [CB-1:0] blended;

   always_comb begin
      src_factor  = pick_factor(lane_cfg.src_factor, src_chan, dst_chan, src_alpha,
                                dst_alpha, const_chan, const_alpha);
      dst_factor  = pick_factor(lane_cfg.dst_factor, src_chan, dst_chan, src_alpha,
                                dst_alpha, const_chan, const_alpha);
      prod_src_in = PW'(src_chan) * PW'(src_factor);
      prod_dst_in = PW'(dst_chan) * PW'(dst_factor);
   end

   always_ff @(posedge clock) begin
      if (pipe_ctrl.load1) begin
         prod_src_ff <= prod_src_in;
         prod_dst_ff <= prod_dst_in;
         src1_ff     <= src_chan;
         dst1_ff     <= dst_chan;
      end
   end

   always_comb begin
      term_src_in = round_div(prod_src_ff);
      term_dst_in = round_div(prod_dst_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_ctrl.load2) begin
         term_src_ff <= term_src_in;
         term_dst_ff <= term_dst_in;
         src2_ff     <= src1_ff;
         dst2_ff     <= dst1_ff;
      end
   end

   always_comb begin
      sum = (CB + 1)'(term_src_ff) + (CB + 1)'(term_dst_ff);
      case (lane_cfg.equation)
         EQ_SUB:     blended = (term_src_ff > term_dst_ff) ? term_src_ff - term_dst_ff : '0;
         EQ_REV_SUB: blended = (term_dst_ff > term_src_ff) ? term_dst_ff - term_src_ff : '0;
         EQ_MIN:     blended = (src2_ff < dst2_ff) ? src2_ff : dst2_ff;
         EQ_MAX:     blended = (src2_ff > dst2_ff) ? src2_ff : dst2_ff;
         default:    blended = sum[CB] ? MAXV : sum[CB-1:0];
      endcase
      lane_result = lane_cfg.blend_en ? blended : src2_ff;
   end

endmodule

// ===== hdl/rbu_merge.sv =====
// rbu_merge: gathers the four lane results, write flags and depth into one result.
// Holds the output register of the result channel. Depends on rbu_pkg.
module rbu_merge #(
   parameter int CHANNEL_BITS = 8,
   parameter int DEPTH_BITS   = 24
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              stage_valid,
   input  logic [rbu_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]      lane_results,
   input  rbu_pkg::rbu_wr_flags_type                         wr_flags,
   input  logic [DEPTH_BITS-1:0]                             depth,
   output logic                                              out_ready,
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   output logic [((4*CHANNEL_BITS+5+DEPTH_BITS+7)/8)*8-1:0]  rsp_tdata
);
   import rbu_pkg::*;

   localparam int RSP_W = ((4 * CHANNEL_BITS + 5 + DEPTH_BITS + 7) / 8) * 8;

   logic             out_valid_in, out_valid_ff;
   logic [RSP_W-1:0] out_data_in, out_data_ff;
   logic             load_out;

   always_comb begin
      out_ready    = !out_valid_ff || rsp_tready;
      load_out     = stage_valid && out_ready;
      out_data_in  = RSP_W'({depth, wr_flags, lane_results});
      out_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== hdl/rgba_blend_unit.sv =====
// rgba_blend_unit: top level of the per-fragment RGBA blend stage.
// Instantiates four rbu_lane channel lanes and the rbu_merge output stage.
// Depends on rbu_pkg, rbu_lane, rbu_merge.
//
// Usage:
//  - req_* is the fragment channel. A transaction carries source colour,
//    destination colour and fragment depth; it is taken when req_tvalid and
//    req_tready are both high.
//  - rsp_* is the result channel: blended colour, per-channel write enables,
//    depth write flag and depth, one transaction per fragment.
//  - csr_* writes one blend register per cycle while csr_we is high; write
//    only while no fragment is in flight.
//  - From accept to rsp_tvalid a fragment passes factor select and multiply,
//    divide-by-full-scale with rounding, then combine into the output register.
//  - Throughput is one fragment per clock while rsp_tready is high; one multiplier
//    per term per lane in stage one, and all stages advance together when unblocked.
//  - When rsp_tready is low the output register holds its result; the stages
//    behind it keep filling until every stage holds a fragment, then
//    req_tready drops. Nothing is lost or repeated.
//  - Reset (synchronous, active high) empties the pipeline and loads the
//    registers with their defaults: source factors one, destination factors
//    zero, add equations, zero constant, write control all masks on with
//    depth write set and blending off.
module rgba_blend_unit #(
   parameter int CHANNEL_BITS = 8,
   parameter int DEPTH_BITS   = 24
) (
   input  logic                                              clock,
   input  logic                                              reset,
   // configuration write port
   input  logic                                              csr_we,
   input  logic [rbu_pkg::CSR_ADDR_BITS-1:0]                 csr_addr,
   input  logic [rbu_pkg::CSR_DATA_BITS-1:0]                 csr_wdata,
   // fragment channel
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   // req_tdata, low bit up: src_red, src_green, src_blue, src_alpha,
   // dst_red, dst_green, dst_blue, dst_alpha, frag_depth, zero fill
   input  logic [((8*CHANNEL_BITS+DEPTH_BITS+7)/8)*8-1:0]    req_tdata,
   // result channel
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   // rsp_tdata, low bit up: out_red, out_green, out_blue, out_alpha,
   // channel_write_enables, depth_write_enable, depth_out, zero fill
   output logic [((4*CHANNEL_BITS+5+DEPTH_BITS+7)/8)*8-1:0]  rsp_tdata
);
   import rbu_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam int DB = DEPTH_BITS;

   // Blend registers
   rbu_factor_type         src_rgb_factor_ff;
   rbu_factor_type         dst_rgb_factor_ff;
   rbu_factor_type         src_alpha_factor_ff;
   rbu_factor_type         dst_alpha_factor_ff;
   rbu_equation_type       rgb_equation_ff;
   rbu_equation_type       alpha_equation_ff;
   logic [CSR_DATA_BITS-1:0] constant_colour_ff;
   logic [WRCTL_BITS-1:0]  write_control_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_rgb_factor_ff   <= FACTOR_ONE;
         dst_rgb_factor_ff   <= FACTOR_ZERO;
         src_alpha_factor_ff <= FACTOR_ONE;
         dst_alpha_factor_ff <= FACTOR_ZERO;
         rgb_equation_ff     <= EQ_ADD;
         alpha_equation_ff   <= EQ_ADD;
         constant_colour_ff  <= '0;
         write_control_ff    <= WRCTL_BITS'(31);
      end else if (csr_we) begin
         unique case (rbu_csr_type'(csr_addr))
            CSR_SRC_RGB_FACTOR:   src_rgb_factor_ff   <= rbu_factor_type'(csr_wdata[3:0]);
            CSR_DST_RGB_FACTOR:   dst_rgb_factor_ff   <= rbu_factor_type'(csr_wdata[3:0]);
            CSR_SRC_ALPHA_FACTOR: src_alpha_factor_ff <= rbu_factor_type'(csr_wdata[3:0]);
            CSR_DST_ALPHA_FACTOR: dst_alpha_factor_ff <= rbu_factor_type'(csr_wdata[3:0]);
            CSR_RGB_EQUATION:     rgb_equation_ff     <= rbu_equation_type'(csr_wdata[2:0]);
            CSR_ALPHA_EQUATION:   alpha_equation_ff   <= rbu_equation_type'(csr_wdata[2:0]);
            CSR_CONSTANT_COLOUR:  constant_colour_ff  <= csr_wdata;
            CSR_WRITE_CONTROL:    write_control_ff    <= csr_wdata[WRCTL_BITS-1:0];
         endcase
      end
   end

   // Lane setup: rgb lanes share one set, the alpha lane has its own.
   rbu_lane_cfg_type rgb_cfg;
   rbu_lane_cfg_type alpha_cfg;

   always_comb begin
      rgb_cfg.src_factor   = src_rgb_factor_ff;
      rgb_cfg.dst_factor   = dst_rgb_factor_ff;
      rgb_cfg.equation     = rgb_equation_ff;
      rgb_cfg.blend_en     = write_control_ff[WRCTL_BLEND_EN];
      alpha_cfg.src_factor = src_alpha_factor_ff;
      alpha_cfg.dst_factor = dst_alpha_factor_ff;
      alpha_cfg.equation   = alpha_equation_ff;
      alpha_cfg.blend_en   = write_control_ff[WRCTL_BLEND_EN];
   end

   // Unpack the fragment. Constant channels past the 32 register bits read as zero.
   logic [NUM_CH-1:0][CB-1:0]          src_chan;
   logic [NUM_CH-1:0][CB-1:0]          dst_chan;
   logic [NUM_CH-1:0][CB-1:0]          const_chan;
   logic [NUM_CH*CB+CSR_DATA_BITS-1:0] const_ext;
   logic [DB-1:0]                      frag_depth;

   always_comb begin
      const_ext = {(NUM_CH * CB)'(0), constant_colour_ff};
      for (int ch = 0; ch < NUM_CH; ch++) begin
         src_chan[ch]   = req_tdata[ch*CB +: CB];
         dst_chan[ch]   = req_tdata[(NUM_CH+ch)*CB +: CB];
         const_chan[ch] = const_ext[ch*CB +: CB];
      end
      frag_depth = req_tdata[2*NUM_CH*CB +: DB];
   end

   // Pipeline control: a stage loads when it is empty or the next one moves.
   logic              v1_in, v1_ff;
   logic              v2_in, v2_ff;
   logic              ready1, ready2, out_ready;
   rbu_pipe_ctrl_type pipe_ctrl;

   always_comb begin
      ready2          = !v2_ff || out_ready;
      ready1          = !v1_ff || ready2;
      pipe_ctrl.load1 = req_tvalid && ready1;
      pipe_ctrl.load2 = v1_ff && ready2;
      v1_in           = pipe_ctrl.load1 ? 1'b1 : (pipe_ctrl.load2 ? 1'b0 : v1_ff);
      v2_in           = pipe_ctrl.load2 ? 1'b1 : (out_ready ? 1'b0 : v2_ff);
   end

   assign req_tready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Sideband: depth and write flags ride along with the colour.
   rbu_wr_flags_type flags_in, flags1_ff, flags2_ff;
   logic [DB-1:0]    depth1_ff, depth2_ff;

   always_comb begin
      flags_in.depth_we = write_control_ff[WRCTL_DEPTH_WE];
      flags_in.chan_we  = write_control_ff[NUM_CH-1:0];
   end

   always_ff @(posedge clock) begin
      if (pipe_ctrl.load1) begin
         flags1_ff <= flags_in;
         depth1_ff <= frag_depth;
      end
      if (pipe_ctrl.load2) begin
         flags2_ff <= flags1_ff;
         depth2_ff <= depth1_ff;
      end
   end

   // Channel lanes
   logic [NUM_CH-1:0][CB-1:0] lane_results;

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      rbu_lane #(
         .CHANNEL_BITS (CB),
         .IS_ALPHA     (ch == ALPHA_CH)
      ) u_lane (
         .clock       (clock),
         .pipe_ctrl   (pipe_ctrl),
         .lane_cfg    ((ch == ALPHA_CH) ? alpha_cfg : rgb_cfg),
         .src_chan    (src_chan[ch]),
         .dst_chan    (dst_chan[ch]),
         .src_alpha   (src_chan[ALPHA_CH]),
         .dst_alpha   (dst_chan[ALPHA_CH]),
         .const_chan  (const_chan[ch]),
         .const_alpha (const_chan[ALPHA_CH]),
         .lane_result (lane_results[ch])
      );
   end

   // Merge and output register
   rbu_merge #(
      .CHANNEL_BITS (CB),
      .DEPTH_BITS   (DB)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .stage_valid  (v2_ff),
      .lane_results (lane_results),
      .wr_flags     (flags2_ff),
      .depth        (depth2_ff),
      .out_ready    (out_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

`ifndef SYNTHESIS
   // An accepted fragment always lands in the first stage.
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted fragment missing from stage 1");

   // A blocked first stage keeps its fragment and its depth.
   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !ready2) |=> (v1_ff && $stable(depth1_ff)))
      else $error("stage 1 dropped or changed a stalled fragment");

   // A blocked second stage keeps its fragment and its depth.
   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !out_ready) |=> (v2_ff && $stable(depth2_ff)))
      else $error("stage 2 dropped or changed a stalled fragment");

   // With every stage full and the receiver stalled, no new fragment is taken.
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("fragment accepted into a full pipeline");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for rgba_blend_unit; predicts every blended pixel
// from its own copy of the blend registers and checks each rsp transaction in order.
// Depends on rbu_pkg and rgba_blend_unit.
module tb;
   import rbu_pkg::*;

   localparam int CHANNEL_BITS = 8;
   localparam int DEPTH_BITS   = 24;
   localparam logic [7:0] FULL = 8'hFF;

   // Fragment as it sits on req_tdata; packed arrays put channel 0 (red) lowest.
   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth;
      logic [3:0][7:0]       dst;
      logic [3:0][7:0]       src;
   } fragment_t;

   // Pixel as it sits on rsp_tdata.
   typedef struct packed {
      logic [2:0]            fill;
      logic [DEPTH_BITS-1:0] depth;
      logic                  depth_we;
      logic [3:0]            chan_we;
      logic [3:0][7:0]       colour;
   } pixel_t;

   // All driven inputs start at known values before the first clock edge.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr  = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata, low bit up: src_red, src_green, src_blue, src_alpha,
   // dst_red, dst_green, dst_blue, dst_alpha, frag_depth
   logic [87:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata, low bit up: out_red, out_green, out_blue, out_alpha,
   // channel_write_enables, depth_write_enable, depth_out, zero fill
   logic [63:0] rsp_tdata;

   // Shadow copy of the blend registers, loaded with the reset defaults.
   rbu_factor_type   src_rgb_code   = FACTOR_ONE;
   rbu_factor_type   dst_rgb_code   = FACTOR_ZERO;
   rbu_factor_type   src_alpha_code = FACTOR_ONE;
   rbu_factor_type   dst_alpha_code = FACTOR_ZERO;
   rbu_equation_type rgb_eq_code    = EQ_ADD;
   rbu_equation_type alpha_eq_code  = EQ_ADD;
   logic [31:0]      blend_constant = '0;
   logic [5:0]       write_ctrl     = 6'd31;

   pixel_t expected_pixels[$];
   int     mismatch_count = 0;
   int     send_idle_pct  = 0;
   int     recv_idle_pct  = 0;
   bit     stall_request  = 1'b0;
   int     hold_left      = 0;

   rgba_blend_unit #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .DEPTH_BITS  (DEPTH_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // Blend weight for one channel; alpha lane colour codes read the alpha component.
   function automatic logic [7:0] factor_value(rbu_factor_type code, int ch, fragment_t f);
      logic [7:0] sa;
      logic [7:0] da;
      logic [7:0] ka;
      logic [7:0] kc;
      sa = f.src[ALPHA_CH];
      da = f.dst[ALPHA_CH];
      ka = blend_constant[ALPHA_CH*8 +: 8];
      kc = blend_constant[ch*8 +: 8];
      case (code)
         FACTOR_ZERO:             return 8'd0;
         FACTOR_ONE:              return FULL;
         FACTOR_SRC_COLOR:        return f.src[ch];
         FACTOR_ONE_MINUS_SRC:    return FULL - f.src[ch];
         FACTOR_DST_COLOR:        return f.dst[ch];
         FACTOR_ONE_MINUS_DST:    return FULL - f.dst[ch];
         FACTOR_SRC_ALPHA:        return sa;
         FACTOR_ONE_MINUS_SRCA:   return FULL - sa;
         FACTOR_DST_ALPHA:        return da;
         FACTOR_ONE_MINUS_DSTA:   return FULL - da;
         FACTOR_CONST_COLOR:      return kc;
         FACTOR_ONE_MINUS_CONST:  return FULL - kc;
         FACTOR_CONST_ALPHA:      return ka;
         FACTOR_ONE_MINUS_CONSTA: return FULL - ka;
         // alpha saturates to full scale; rgb takes min(src alpha, 1 - dst alpha)
         FACTOR_SATURATE: return (ch == ALPHA_CH) ? FULL : ((sa < FULL - da) ? sa : FULL - da);
         default:                 return FULL;  // unknown code acts as one
      endcase
   endfunction

   // colour * weight / 255, rounded to nearest (no ties since 255 is odd)
   function automatic logic [7:0] weigh(logic [7:0] c, logic [7:0] w);
      int p;
      p = int'(c) * int'(w) + 127;
      return 8'(p / 255);
   endfunction

   function automatic logic [7:0] combine_terms(rbu_equation_type eq, logic [7:0] a,
                                                logic [7:0] b, logic [7:0] s, logic [7:0] d);
      int sum;
      sum = int'(a) + int'(b);
      case (eq)
         EQ_SUB:     return (a > b) ? a - b : 8'd0;
         EQ_REV_SUB: return (b > a) ? b - a : 8'd0;
         EQ_MIN:     return (s < d) ? s : d;   // min and max ignore the factors
         EQ_MAX:     return (s > d) ? s : d;
         default:    return (sum > 255) ? FULL : sum[7:0];  // unknown acts as add
      endcase
   endfunction

   function automatic pixel_t blend_pixel(fragment_t f);
      pixel_t           p;
      rbu_factor_type   sf;
      rbu_factor_type   df;
      rbu_equation_type eq;
      p = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (!write_ctrl[WRCTL_BLEND_EN]) begin
            p.colour[ch] = f.src[ch];
         end else begin
            sf = (ch == ALPHA_CH) ? src_alpha_code : src_rgb_code;
            df = (ch == ALPHA_CH) ? dst_alpha_code : dst_rgb_code;
            eq = (ch == ALPHA_CH) ? alpha_eq_code : rgb_eq_code;
            p.colour[ch] = combine_terms(eq, weigh(f.src[ch], factor_value(sf, ch, f)),
                                         weigh(f.dst[ch], factor_value(df, ch, f)),
                                         f.src[ch], f.dst[ch]);
         end
      end
      // masked channels still carry their colour; only the enable bit drops
      p.chan_we  = write_ctrl[3:0];
      p.depth_we = write_ctrl[WRCTL_DEPTH_WE];
      p.depth    = f.depth;
      return p;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Channels and depth lean toward their extremes now and then.
   function automatic fragment_t random_fragment();
      fragment_t f;
      int        pick;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         pick = $urandom_range(0, 9);
         f.src[ch] = (pick == 0) ? 8'd0 : (pick == 1) ? FULL : 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 9);
         f.dst[ch] = (pick == 0) ? 8'd0 : (pick == 1) ? FULL : 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 9);
      f.depth = (pick == 0) ? '0 : (pick == 1) ? '1 : DEPTH_BITS'($urandom);
      return f;
   endfunction

   // Offer one fragment, starting at a falling edge; return at the falling edge
   // after it was taken. Valid is left high so back-to-back transactions need no gap.
   task automatic send_fragment(input fragment_t f);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      do @(posedge clock); while (!req_tready);
      expected_pixels.push_back(blend_pixel(f));
      @(negedge clock);
   endtask

   // Drop valid and hold off until every pixel has come back.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register write; call only while the pipeline is empty.
   task automatic write_reg(input rbu_csr_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SRC_RGB_FACTOR:   src_rgb_code   = rbu_factor_type'(value[FACTOR_BITS-1:0]);
         CSR_DST_RGB_FACTOR:   dst_rgb_code   = rbu_factor_type'(value[FACTOR_BITS-1:0]);
         CSR_SRC_ALPHA_FACTOR: src_alpha_code = rbu_factor_type'(value[FACTOR_BITS-1:0]);
         CSR_DST_ALPHA_FACTOR: dst_alpha_code = rbu_factor_type'(value[FACTOR_BITS-1:0]);
         CSR_RGB_EQUATION:     rgb_eq_code    = rbu_equation_type'(value[EQUATION_BITS-1:0]);
         CSR_ALPHA_EQUATION:   alpha_eq_code  = rbu_equation_type'(value[EQUATION_BITS-1:0]);
         CSR_CONSTANT_COLOUR:  blend_constant = value;
         CSR_WRITE_CONTROL:    write_ctrl     = value[WRCTL_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Rewrite every register; unused upper bits are sometimes set to probe masking,
   // and the constant and write control sometimes land on their extremes.
   task automatic load_random_blend_setup();
      logic [31:0] value;
      int          pick;
      for (int i = 0; i < 8; i++) begin
         pick = $urandom_range(0, 7);
         case (rbu_csr_type'(i))
            CSR_RGB_EQUATION, CSR_ALPHA_EQUATION: begin
               value = (pick == 0) ? $urandom : $urandom_range(0, 7);
            end
            CSR_CONSTANT_COLOUR: begin
               value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
            end
            CSR_WRITE_CONTROL: begin
               value = $urandom;
               value[WRCTL_BLEND_EN] = ($urandom_range(0, 4) != 0);
               if (pick == 0) value = 32'd0;
               if (pick == 1) value = 32'd63;
            end
            default: begin
               value = (pick == 0) ? $urandom : $urandom_range(0, 15);
            end
         endcase
         write_reg(rbu_csr_type'(i), value);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Reset defaults: blending off, so the source passes through; all masks and
   // depth write on. Then blending off with depth write off and a partial mask.
   task automatic test_reset_defaults();
      fragment_t f;
      f = '0;
      send_fragment(f);
      f = '1;
      send_fragment(f);
      send_fragment(random_fragment());
      drain_pipeline();
      write_reg(CSR_WRITE_CONTROL, 32'h0A);
      send_fragment(random_fragment());
      drain_pipeline();
   endtask

   // Walk every factor code, the unknown one included, through all four factor slots.
   task automatic test_factor_codes();
      write_reg(CSR_WRITE_CONTROL, 32'h3F);
      write_reg(CSR_RGB_EQUATION, 32'(EQ_ADD));
      write_reg(CSR_ALPHA_EQUATION, 32'(EQ_ADD));
      write_reg(CSR_CONSTANT_COLOUR, 32'h80C0_4010);
      for (int code = 0; code < 16; code++) begin
         write_reg(CSR_SRC_RGB_FACTOR, code);
         write_reg(CSR_DST_RGB_FACTOR, (code + 7) % 16);
         write_reg(CSR_SRC_ALPHA_FACTOR, code);
         write_reg(CSR_DST_ALPHA_FACTOR, (code + 3) % 16);
         send_fragment(random_fragment());
         drain_pipeline();
      end
   endtask

   // Every equation code with unit factors: add saturates, subtract clamps at
   // zero, min/max pick raw colours, unknown codes add. Masks and depth write vary.
   task automatic test_equations();
      fragment_t f;
      write_reg(CSR_SRC_RGB_FACTOR, 32'(FACTOR_ONE));
      write_reg(CSR_DST_RGB_FACTOR, 32'(FACTOR_ONE));
      write_reg(CSR_SRC_ALPHA_FACTOR, 32'(FACTOR_ONE));
      write_reg(CSR_DST_ALPHA_FACTOR, 32'(FACTOR_ONE));
      f.src = {8'd0, 8'd255, 8'd200, 8'd10};
      f.dst = {8'd255, 8'd255, 8'd100, 8'd20};
      for (int eq = 0; eq < 8; eq++) begin
         write_reg(CSR_RGB_EQUATION, eq);
         write_reg(CSR_ALPHA_EQUATION, 7 - eq);
         write_reg(CSR_WRITE_CONTROL, 32'h20 | ((eq * 5) & 32'h1F));
         f.depth = eq[0] ? '1 : '0;
         send_fragment(f);
         drain_pipeline();
      end
   endtask

   // Hold the result side off for a long stretch while fragments keep coming, so
   // the pipeline fills and stalls its input; then pause the sender until empty.
   task automatic test_output_stall();
      load_random_blend_setup();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = 1'b1;
      repeat (30) send_fragment(random_fragment());
      drain_pipeline();
      repeat (10) send_fragment(random_fragment());
      drain_pipeline();
   endtask

   // Random fragments under random setups, reconfiguring every 25 transactions.
   task automatic run_random_traffic(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 25 == 0) begin
            drain_pipeline();
            load_random_blend_setup();
         end
         send_fragment(random_fragment());
      end
      drain_pipeline();
   endtask

   // ---------------------------------------------------------------- result side

   // Drive rsp_tready at the falling edge; a stall request is counted down here.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_request) begin
            hold_left     = 64;
            stall_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // Compare each accepted pixel against the oldest prediction.
   always @(posedge clock) begin
      pixel_t got;
      pixel_t want;
      string  channel_name[4];
      channel_name = '{"out_red", "out_green", "out_blue", "out_alpha"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            for (int ch = 0; ch < NUM_CH; ch++)
               check_field(channel_name[ch], 32'(want.colour[ch]), 32'(got.colour[ch]));
            check_field("channel_write_enables", 32'(want.chan_we), 32'(got.chan_we));
            check_field("depth_write_enable", 32'(want.depth_we), 32'(got.depth_we));
            check_field("depth_out", 32'(want.depth), 32'(got.depth));
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_factor_codes();
      test_equations();
      test_output_stall();
      run_random_traffic(145, 11, 70);
      run_random_traffic(145, 70, 11);
      run_random_traffic(145, 0, 0);

      drain_pipeline();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
